// ===== rtl/gmt_pkg.sv =====
// shared types, constants and state encodings for the grid mesh triangulator
`default_nettype none
package gmt_pkg;
  localparam int COORD_WIDTH    = 16;
  localparam int NORM_WIDTH     = 16;
  localparam int TEX_WIDTH      = 17;
  localparam int POINT_WIDTH    = 3 * COORD_WIDTH;
  localparam int CFG_ADDR_WIDTH = 8;
  localparam int CFG_DATA_WIDTH = 17;
  localparam int SIZE_WIDTH     = 9;
  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_MAX_ROWS   = 256;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_GRID_ROWS = 8'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_GRID_COLS = 8'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_U_STEP    = 8'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_V_STEP    = 8'd3;

  localparam logic [SIZE_WIDTH-1:0] GRID_SIZE_RST = 9'd2;
  localparam logic [TEX_WIDTH-1:0]  TEX_ONE       = 17'd65536;
  localparam logic [TEX_WIDTH-1:0]  STEP_RST      = 17'd32768;
  localparam logic [14:0]           NORM_ONE      = 15'd16384;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } point_t;

  typedef struct packed {
    logic                          cmd;
    logic signed [COORD_WIDTH-1:0] pos_in_x;
    logic signed [COORD_WIDTH-1:0] pos_in_y;
    logic signed [COORD_WIDTH-1:0] pos_in_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vert_x;
    logic signed [COORD_WIDTH-1:0] vert_y;
    logic signed [COORD_WIDTH-1:0] vert_z;
    logic signed [NORM_WIDTH-1:0]  norm_x;
    logic signed [NORM_WIDTH-1:0]  norm_y;
    logic signed [NORM_WIDTH-1:0]  norm_z;
    logic [TEX_WIDTH-1:0]          tex_u;
    logic [TEX_WIDTH-1:0]          tex_v;
    logic                          last_vertex;
    logic                          grid_done;
    logic                          overflow_error;
  } out_beat_t;

  typedef enum logic [3:0] {
    NS_IDLE, NS_MUL, NS_ABS, NS_SCALE, NS_SQ, NS_SQRT,
    NS_DIV_INIT, NS_DIV, NS_QUOT, NS_DONE
  } norm_state_t;

  typedef enum logic [3:0] {
    TS_IDLE, TS_RD_D, TS_RD_A, TS_CAP_A, TS_N1, TS_N1_WAIT, TS_N2, TS_N2_WAIT,
    TS_EMIT, TS_ERR, TS_WR_PREV, TS_WR_END
  } top_state_t;
endpackage
`default_nettype wire

// ===== rtl/grid_mesh_triangulator_core.sv =====
// top level: grid sequencer, line store, shared normal unit and result register
//
// Points stream in row-major order; every point at row>0, col>0 closes a quad and
// yields six vertex beats (A B C, then A C D) with position, Q1.14 unit face
// normal and Q1.16 texture coordinates. A point taken after the grid is full
// yields one overflow beat; a clear command restarts the grid and yields nothing.
// A point that closes a quad occupies the block for two passes through the shared
// normal unit (seven multiply steps, a one bit a cycle scaling pass, a 32 step
// square root and three 15 step divides each), plus line store reads and six
// result beats. A degenerate triangle skips the scaling, root and divides.
// Output stalls stretch the six beats. A point that closes no quad only writes
// the line store, an overflow point waits for a free output slot and a clear
// command only resets the grid position.
// The input is stalled while an item is in progress; a finished beat waits in the
// output register without holding back the next item.
`default_nettype none
module grid_mesh_triangulator_core
  import gmt_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_beat_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_beat_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS + 1);

  top_state_t st_r, st_nxt;

  // configuration
  logic [SIZE_WIDTH-1:0] grid_rows_r, grid_cols_r;
  logic [TEX_WIDTH-1:0]  u_step_r, v_step_r;

  // grid position and held points
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  point_t        prev_r, p_r, a_r, d_r, n1_r, n2_r;
  logic          row_end_r, done_r;
  logic [2:0]    k_r;

  // result register
  logic      out_valid_r;
  out_beat_t out_data_r;

  logic [RW-1:0] rows_eff;
  logic [CW:0]   cols_eff;
  logic          accept, full, row_end, grid_end, quad, slot_free;

  // line store
  logic          ram_we;
  logic [CW-1:0] ram_waddr, ram_raddr;
  point_t        ram_wdata;
  logic [POINT_WIDTH-1:0] ram_rdata;

  // normal unit
  logic   nu_start, nu_done;
  point_t nu_b, nu_c, nu_norm;

  // vertex select for the current beat
  point_t        v_pos, v_norm;
  logic [CW-1:0] v_col;
  logic [RW-1:0] v_row;
  logic [CW+TEX_WIDTH-1:0] u_prod;
  logic [RW+TEX_WIDTH-1:0] v_prod;
  logic [TEX_WIDTH-1:0]    tex_u, tex_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_SIZE_RST;
      grid_cols_r <= GRID_SIZE_RST;
      u_step_r    <= STEP_RST;
      v_step_r    <= STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_data[SIZE_WIDTH-1:0];
        REG_GRID_COLS: grid_cols_r <= cfg_data[SIZE_WIDTH-1:0];
        REG_U_STEP:    u_step_r    <= cfg_data;
        REG_V_STEP:    v_step_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes clamped to what the line store and row counter hold
  always_comb begin
    if (grid_rows_r == '0) rows_eff = RW'(1);
    else if (32'(grid_rows_r) > MAX_ROWS) rows_eff = RW'(MAX_ROWS);
    else rows_eff = RW'(grid_rows_r);
    if (grid_cols_r == '0) cols_eff = (CW+1)'(1);
    else if (32'(grid_cols_r) > MAX_COLS) cols_eff = (CW+1)'(MAX_COLS);
    else cols_eff = (CW+1)'(grid_cols_r);
  end

  assign in_stall  = (st_r != TS_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = 32'(row_r) >= 32'(rows_eff);
  assign row_end   = 32'(col_r) + 32'd1 >= 32'(cols_eff);
  assign grid_end  = row_end && (32'(row_r) + 32'd1 >= 32'(rows_eff));
  assign quad      = (row_r != '0) && (col_r != '0);
  assign slot_free = !out_valid_r || !out_stall;

  gmt_ram #(
    .WIDTH(POINT_WIDTH),
    .DEPTH(MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // D sits at the current column, A one to the left
  assign ram_raddr = (st_r == TS_RD_A) ? col_r - CW'(1) : col_r;

  // old previous point goes one left, the row's last point into its own slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col_r - CW'(1);
    ram_wdata = prev_r;
    if (st_r == TS_WR_PREV) begin
      ram_we = (col_r != '0);
    end else if (st_r == TS_WR_END) begin
      ram_we    = row_end_r;
      ram_waddr = col_r;
      ram_wdata = p_r;
    end
  end

  assign nu_start = (st_r == TS_N1) || (st_r == TS_N2);
  assign nu_b     = (st_r == TS_N1) ? prev_r : p_r;
  assign nu_c     = (st_r == TS_N1) ? p_r : d_r;

  gmt_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nu_start),
    .a_pt  (a_r),
    .b_pt  (nu_b),
    .c_pt  (nu_c),
    .done  (nu_done),
    .norm  (nu_norm)
  );

  // vertex order A B C A C D
  always_comb begin
    v_norm = (k_r < 3'd3) ? n1_r : n2_r;
    case (k_r)
      3'd0: begin v_pos = a_r;    v_col = col_r - CW'(1); v_row = row_r - RW'(1); end
      3'd1: begin v_pos = prev_r; v_col = col_r - CW'(1); v_row = row_r;          end
      3'd2: begin v_pos = p_r;    v_col = col_r;          v_row = row_r;          end
      3'd3: begin v_pos = a_r;    v_col = col_r - CW'(1); v_row = row_r - RW'(1); end
      3'd4: begin v_pos = p_r;    v_col = col_r;          v_row = row_r;          end
      default: begin v_pos = d_r; v_col = col_r;          v_row = row_r - RW'(1); end
    endcase
  end

  assign u_prod = (CW+TEX_WIDTH)'(v_col) * (CW+TEX_WIDTH)'(u_step_r);
  assign v_prod = (RW+TEX_WIDTH)'(v_row) * (RW+TEX_WIDTH)'(v_step_r);
  // u saturates at one, v floors at zero
  assign tex_u  = (u_prod > (CW+TEX_WIDTH)'(TEX_ONE)) ? TEX_ONE : u_prod[TEX_WIDTH-1:0];
  assign tex_v  = (v_prod >= (RW+TEX_WIDTH)'(TEX_ONE)) ? '0
                : TEX_ONE - v_prod[TEX_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      TS_IDLE: begin
        if (accept && !in_data.cmd) begin
          if (full) st_nxt = TS_ERR;
          else if (quad) st_nxt = TS_RD_D;
          else st_nxt = TS_WR_PREV;
        end
      end
      TS_RD_D:    st_nxt = TS_RD_A;
      TS_RD_A:    st_nxt = TS_CAP_A;
      TS_CAP_A:   st_nxt = TS_N1;
      TS_N1:      st_nxt = TS_N1_WAIT;
      TS_N1_WAIT: if (nu_done) st_nxt = TS_N2;
      TS_N2:      st_nxt = TS_N2_WAIT;
      TS_N2_WAIT: if (nu_done) st_nxt = TS_EMIT;
      TS_EMIT:    if (slot_free && k_r == 3'd5) st_nxt = TS_WR_PREV;
      TS_ERR:     if (slot_free) st_nxt = TS_IDLE;
      TS_WR_PREV: st_nxt = TS_WR_END;
      TS_WR_END:  st_nxt = TS_IDLE;
      default:    st_nxt = TS_IDLE;
    endcase
  end

  // grid position and previous point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
      k_r    <= '0;
    end else begin
      if (accept && in_data.cmd) begin
        col_r  <= '0;
        row_r  <= '0;
        prev_r <= '0;
      end
      if (st_r == TS_N2_WAIT) k_r <= '0;
      if (st_r == TS_EMIT && slot_free) k_r <= k_r + 3'd1;
      if (st_r == TS_WR_END) begin
        prev_r <= p_r;
        if (row_end_r) begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  // held points and normals
  always_ff @(posedge clk) begin
    if (accept) begin
      p_r       <= '{x: in_data.pos_in_x, y: in_data.pos_in_y, z: in_data.pos_in_z};
      row_end_r <= row_end;
      done_r    <= grid_end;
    end
    if (st_r == TS_RD_A) d_r <= point_t'(ram_rdata);
    if (st_r == TS_CAP_A) a_r <= point_t'(ram_rdata);
    if (st_r == TS_N1_WAIT && nu_done) n1_r <= nu_norm;
    if (st_r == TS_N2_WAIT && nu_done) n2_r <= nu_norm;
  end

  // result register, refilled as soon as the held beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((st_r == TS_EMIT || st_r == TS_ERR) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == TS_ERR && slot_free) begin
      // overflow beat: flag only, every other field zero
      out_data_r.vert_x         <= '0;
      out_data_r.vert_y         <= '0;
      out_data_r.vert_z         <= '0;
      out_data_r.norm_x         <= '0;
      out_data_r.norm_y         <= '0;
      out_data_r.norm_z         <= '0;
      out_data_r.tex_u          <= '0;
      out_data_r.tex_v          <= '0;
      out_data_r.last_vertex    <= 1'b0;
      out_data_r.grid_done      <= 1'b0;
      out_data_r.overflow_error <= 1'b1;
    end else if (st_r == TS_EMIT && slot_free) begin
      out_data_r.vert_x         <= v_pos.x;
      out_data_r.vert_y         <= v_pos.y;
      out_data_r.vert_z         <= v_pos.z;
      out_data_r.norm_x         <= v_norm.x;
      out_data_r.norm_y         <= v_norm.y;
      out_data_r.norm_z         <= v_norm.z;
      out_data_r.tex_u          <= tex_u;
      out_data_r.tex_v          <= tex_v;
      out_data_r.last_vertex    <= (k_r == 3'd5);
      out_data_r.grid_done      <= done_r;
      out_data_r.overflow_error <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

// ===== rtl/gmt_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module gmt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/gmt_norm.sv =====
// iterative unit normal: cross product, scale, square root and divide; products and squares share one multiplier
`default_nettype none
module gmt_norm
  import gmt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  point_t a_pt,
  input  point_t b_pt,
  input  point_t c_pt,
  output logic   done,
  output point_t norm
);
  norm_state_t st_r, st_nxt;

  logic signed [COORD_WIDTH:0]   e1_r [3];
  logic signed [COORD_WIDTH:0]   e2_r [3];
  logic [2:0]                    step_r;
  logic [1:0]                    comp_r;
  logic [3:0]                    cnt_r;
  logic signed [63:0]            prod_r, acc_r;
  logic signed [35:0]            cr_r [3];
  logic [35:0]                   mag_r [3];
  logic [2:0]                    neg_r;
  logic [63:0]                   sum_r, s_r, res_r, bit_r;
  logic [31:0]                   len_r, rem_r;
  logic [14:0]                   low_r, quo_r;
  logic signed [NORM_WIDTH-1:0]  norm_r [3];

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [35:0]        m_max;
  logic [63:0]        rb;
  logic               ge;
  logic [45:0]        num;
  logic [32:0]        t;
  logic [14:0]        q;

  function automatic logic signed [COORD_WIDTH:0] dif(input logic signed [COORD_WIDTH-1:0] p,
                                                      input logic signed [COORD_WIDTH-1:0] o);
    dif = (COORD_WIDTH+1)'(p) - (COORD_WIDTH+1)'(o);
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_r == NS_MUL) begin
      case (step_r)
        3'd0: begin mul_a = 32'(e1_r[1]); mul_b = 32'(e2_r[2]); end
        3'd1: begin mul_a = 32'(e1_r[2]); mul_b = 32'(e2_r[1]); end
        3'd2: begin mul_a = 32'(e1_r[2]); mul_b = 32'(e2_r[0]); end
        3'd3: begin mul_a = 32'(e1_r[0]); mul_b = 32'(e2_r[2]); end
        3'd4: begin mul_a = 32'(e1_r[0]); mul_b = 32'(e2_r[1]); end
        3'd5: begin mul_a = 32'(e1_r[1]); mul_b = 32'(e2_r[0]); end
        default: ;
      endcase
    end else if (st_r == NS_SQ) begin
      case (step_r)
        3'd0: begin mul_a = $signed({1'b0, mag_r[0][30:0]}); mul_b = mul_a; end
        3'd1: begin mul_a = $signed({1'b0, mag_r[1][30:0]}); mul_b = mul_a; end
        3'd2: begin mul_a = $signed({1'b0, mag_r[2][30:0]}); mul_b = mul_a; end
        default: ;
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    m_max = mag_r[0];
    if (mag_r[1] > m_max) m_max = mag_r[1];
    if (mag_r[2] > m_max) m_max = mag_r[2];
  end

  assign rb  = res_r + bit_r;
  assign ge  = s_r >= rb;
  assign num = {mag_r[comp_r][30:0], 14'd0} + 46'(len_r >> 1);
  assign t   = {rem_r, low_r[14]};
  assign q   = (quo_r > NORM_ONE) ? NORM_ONE : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= NS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      NS_IDLE:     if (start) st_nxt = NS_MUL;
      NS_MUL:      if (step_r == 3'd6) st_nxt = NS_ABS;
      NS_ABS: begin
        if (cr_r[0] == '0 && cr_r[1] == '0 && cr_r[2] == '0) st_nxt = NS_DONE;
        else st_nxt = NS_SCALE;
      end
      NS_SCALE:    if (m_max[35:31] == '0 && m_max[30]) st_nxt = NS_SQ;
      NS_SQ:       if (step_r == 3'd3) st_nxt = NS_SQRT;
      NS_SQRT:     if (bit_r == 64'd1) st_nxt = NS_DIV_INIT;
      NS_DIV_INIT: st_nxt = NS_DIV;
      NS_DIV:      if (cnt_r == 4'd14) st_nxt = NS_QUOT;
      NS_QUOT:     st_nxt = (comp_r == 2'd2) ? NS_DONE : NS_DIV_INIT;
      NS_DONE:     st_nxt = NS_IDLE;
      default:     st_nxt = NS_IDLE;
    endcase
  end

  assign done = (st_r == NS_DONE);
  assign norm = '{x: norm_r[0], y: norm_r[1], z: norm_r[2]};

  always_ff @(posedge clk) begin
    prod_r <= prod;
    case (st_r)
      NS_IDLE: begin
        if (start) begin
          e1_r[0] <= dif(b_pt.x, a_pt.x);
          e1_r[1] <= dif(b_pt.y, a_pt.y);
          e1_r[2] <= dif(b_pt.z, a_pt.z);
          e2_r[0] <= dif(c_pt.x, a_pt.x);
          e2_r[1] <= dif(c_pt.y, a_pt.y);
          e2_r[2] <= dif(c_pt.z, a_pt.z);
          step_r  <= '0;
        end
      end
      NS_MUL: begin
        step_r <= step_r + 3'd1;
        case (step_r)
          3'd1, 3'd3, 3'd5: acc_r <= prod_r;
          3'd2: cr_r[0] <= 36'(acc_r - prod_r);
          3'd4: cr_r[1] <= 36'(acc_r - prod_r);
          3'd6: cr_r[2] <= 36'(acc_r - prod_r);
          default: ;
        endcase
      end
      NS_ABS: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i]  <= cr_r[i][35] ? 36'(-cr_r[i]) : 36'(cr_r[i]);
          neg_r[i]  <= cr_r[i][35];
          norm_r[i] <= '0;
        end
        comp_r <= '0;
      end
      NS_SCALE: begin
        // one bit a cycle until the largest magnitude lies in [2^30, 2^31)
        if (m_max[35:31] != '0) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (!m_max[30]) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end else begin
          step_r <= '0;
          sum_r  <= '0;
        end
      end
      NS_SQ: begin
        step_r <= step_r + 3'd1;
        if (step_r != 3'd0) sum_r <= sum_r + 64'(prod_r);
        if (step_r == 3'd3) begin
          s_r   <= sum_r + 64'(prod_r);
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      NS_SQRT: begin
        if (ge) begin
          s_r   <= s_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) len_r <= ge ? 32'((res_r >> 1) + bit_r) : 32'(res_r >> 1);
      end
      NS_DIV_INIT: begin
        rem_r <= 32'(num >> 15);
        low_r <= num[14:0];
        quo_r <= '0;
        cnt_r <= '0;
      end
      NS_DIV: begin
        if (t >= {1'b0, len_r}) begin
          rem_r <= 32'(t - {1'b0, len_r});
          quo_r <= {quo_r[13:0], 1'b1};
        end else begin
          rem_r <= t[31:0];
          quo_r <= {quo_r[13:0], 1'b0};
        end
        low_r <= low_r << 1;
        cnt_r <= cnt_r + 4'd1;
      end
      NS_QUOT: begin
        norm_r[comp_r] <= neg_r[comp_r] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        comp_r <= comp_r + 2'd1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
